/* sv/tjw_pkg.sv */
// shared types and codes for the transfer job watchdog
// used by the interfaces and every module of the block
package tjw_pkg;

    localparam int TimeW   = 32;
    localparam int LimitW  = 16;
    localparam int AddrW   = 7;
    localparam int CfgIdxW = 2;

    // command codes
    localparam logic [1:0] FUNC_TICK    = 2'd0;
    localparam logic [1:0] FUNC_BACKUP  = 2'd1;
    localparam logic [1:0] FUNC_RESTORE = 2'd2;
    localparam logic [1:0] FUNC_CLEAR   = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE         = 2'd0;
    localparam logic [1:0] ERR_SEND_TIMEOUT = 2'd1;
    localparam logic [1:0] ERR_NO_RESPONSE  = 2'd2;

    // configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_SEND_TIMEOUT     = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_RESPONSE_TIMEOUT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_QUIET_WINDOW     = 2'd2;
    localparam logic [CfgIdxW-1:0] CFG_HARD_CAP         = 2'd3;

    typedef struct packed {
        logic [1:0]       func;
        logic [TimeW-1:0] now_ms;
        logic [AddrW-1:0] module_address;
        logic [AddrW-1:0] card_address;
        logic             gate_open;
        logic             send_ok;
        logic [TimeW-1:0] activity_count;
    } cmd_t;

    typedef struct packed {
        logic [2:0]       job_state;
        logic [1:0]       error_code;
        logic             start_status;
        logic             send_strobe;
        logic             send_is_restore;
        logic [AddrW-1:0] send_module;
        logic [AddrW-1:0] send_card;
    } res_t;

    typedef struct packed {
        logic [LimitW-1:0] send_timeout;
        logic [LimitW-1:0] response_timeout;
        logic [LimitW-1:0] quiet_window;
        logic [LimitW-1:0] hard_cap;
    } cfg_t;

endpackage

/* sv/tjw_if.sv */
// command and result channels of the transfer job watchdog
// depends on tjw_pkg for field widths
interface tjw_cmd_if
    import tjw_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [1:0]          func;
    logic [TimeW-1:0]    now_ms;
    logic [AddrW-1:0]    module_address;
    logic [AddrW-1:0]    card_address;
    logic                gate_open;
    logic                send_ok;
    logic [TimeW-1:0]    activity_count;

    modport source (
        output valid, func, now_ms, module_address, card_address,
               gate_open, send_ok, activity_count,
        input  ready
    );
    modport sink (
        input  valid, func, now_ms, module_address, card_address,
               gate_open, send_ok, activity_count,
        output ready
    );
endinterface

interface tjw_res_if
    import tjw_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [2:0]       job_state;
    logic [1:0]       error_code;
    logic             start_status;
    logic             send_strobe;
    logic             send_is_restore;
    logic [AddrW-1:0] send_module;
    logic [AddrW-1:0] send_card;

    modport source (
        output valid, job_state, error_code, start_status, send_strobe,
               send_is_restore, send_module, send_card,
        input  ready
    );
    modport sink (
        input  valid, job_state, error_code, start_status, send_strobe,
               send_is_restore, send_module, send_card,
        output ready
    );
endinterface

/* sv/tjw_cfg.sv */
// timeout and window limit registers of the transfer job watchdog
// depends on tjw_pkg
module tjw_cfg
    import tjw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [LimitW-1:0]  cfg_wdata,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SEND_TIMEOUT:     cfg_next.send_timeout     = cfg_wdata;
                CFG_RESPONSE_TIMEOUT: cfg_next.response_timeout = cfg_wdata;
                CFG_QUIET_WINDOW:     cfg_next.quiet_window     = cfg_wdata;
                CFG_HARD_CAP:         cfg_next.hard_cap         = cfg_wdata;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.send_timeout     <= 16'd1000;
            cfg_reg.response_timeout <= 16'd2000;
            cfg_reg.quiet_window     <= 16'd500;
            cfg_reg.hard_cap         <= 16'd30000;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* sv/tjw_in_stage.sv */
// input register of the transfer job watchdog: holds one accepted command
// depends on tjw_pkg
module tjw_in_stage
    import tjw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_item,
    input  logic take,
    output logic item_valid,
    output cmd_t item
);

    logic valid_reg;
    logic valid_next;
    cmd_t item_reg;
    logic accept;

    assign in_ready = !valid_reg || take;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_item;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

/* sv/tjw_fsm.sv */
// job state machine and result register of the transfer job watchdog
// depends on tjw_pkg
module tjw_fsm
    import tjw_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic item_valid,
    input  cmd_t item,
    output logic take,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    typedef enum logic [2:0] {
        ST_IDLE     = 3'd0,
        ST_SENDING  = 3'd1,
        ST_WAITING  = 3'd2,
        ST_TRANSFER = 3'd3,
        ST_DONE     = 3'd4,
        ST_FAILED   = 3'd5
    } state_t;

    state_t           state_reg,      state_next;
    logic [1:0]       error_reg,      error_next;
    logic [AddrW-1:0] module_reg,     module_next;
    logic [AddrW-1:0] card_reg,       card_next;
    logic             restore_reg,    restore_next;
    logic [TimeW-1:0] job_start_reg,  job_start_next;
    logic [TimeW-1:0] phase_start_reg, phase_start_next;
    logic [TimeW-1:0] act_base_reg,   act_base_next;
    logic [TimeW-1:0] act_last_reg,   act_last_next;
    logic [TimeW-1:0] change_reg,     change_next;
    logic             status_reg,     status_next;
    logic             strobe_reg,     strobe_next;
    logic             valid_reg,      valid_next;

    logic             busy;
    logic [TimeW-1:0] job_elapsed;
    logic [TimeW-1:0] phase_elapsed;
    logic [TimeW-1:0] change_base;
    logic [TimeW-1:0] quiet_elapsed;

    assign take = item_valid && (!valid_reg || res_ready);
    assign busy = (state_reg == ST_SENDING) || (state_reg == ST_WAITING) ||
                  (state_reg == ST_TRANSFER);

    // all elapsed times wrap modulo 2^32
    assign job_elapsed   = item.now_ms - job_start_reg;
    assign phase_elapsed = item.now_ms - phase_start_reg;
    assign change_base   = (item.activity_count != act_last_reg) ? item.now_ms : change_reg;
    assign quiet_elapsed = item.now_ms - change_base;

    always_comb
    begin
        state_next       = state_reg;
        error_next       = error_reg;
        module_next      = module_reg;
        card_next        = card_reg;
        restore_next     = restore_reg;
        job_start_next   = job_start_reg;
        phase_start_next = phase_start_reg;
        act_base_next    = act_base_reg;
        act_last_next    = act_last_reg;
        change_next      = change_reg;
        status_next      = 1'b0;
        strobe_next      = 1'b0;

        unique case (item.func)
            FUNC_TICK:
            begin
                unique case (state_reg)
                    ST_SENDING:
                    begin
                        if (job_elapsed > {16'd0, cfg.send_timeout})
                        begin
                            state_next = ST_FAILED;
                            error_next = ERR_SEND_TIMEOUT;
                        end
                        else if (item.gate_open && item.send_ok)
                        begin
                            act_base_next    = item.activity_count;
                            act_last_next    = item.activity_count;
                            phase_start_next = item.now_ms;
                            state_next       = ST_WAITING;
                            strobe_next      = 1'b1;
                        end
                    end
                    ST_WAITING:
                    begin
                        if (item.activity_count != act_base_reg)
                        begin
                            act_last_next = item.activity_count;
                            change_next   = item.now_ms;
                            state_next    = ST_TRANSFER;
                        end
                        else if (phase_elapsed > {16'd0, cfg.response_timeout})
                        begin
                            state_next = ST_FAILED;
                            error_next = ERR_NO_RESPONSE;
                        end
                    end
                    ST_TRANSFER:
                    begin
                        act_last_next = item.activity_count;
                        change_next   = change_base;
                        // quiet window first, then the cap since job start
                        if (quiet_elapsed > {16'd0, cfg.quiet_window})
                            state_next = ST_DONE;
                        else if (job_elapsed > {16'd0, cfg.hard_cap})
                            state_next = ST_DONE;
                    end
                    default:
                    begin
                        state_next = state_reg;
                    end
                endcase
            end
            FUNC_CLEAR:
            begin
                if ((state_reg == ST_DONE) || (state_reg == ST_FAILED))
                    state_next = ST_IDLE;
            end
            FUNC_BACKUP, FUNC_RESTORE:
            begin
                if (busy)
                begin
                    status_next = 1'b1;
                end
                else
                begin
                    module_next      = item.module_address;
                    card_next        = item.card_address;
                    restore_next     = (item.func == FUNC_RESTORE);
                    error_next       = ERR_NONE;
                    job_start_next   = item.now_ms;
                    phase_start_next = item.now_ms;
                    state_next       = ST_SENDING;
                end
            end
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (res_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            error_reg       <= ERR_NONE;
            module_reg      <= '0;
            card_reg        <= '0;
            restore_reg     <= 1'b0;
            job_start_reg   <= '0;
            phase_start_reg <= '0;
            act_base_reg    <= '0;
            act_last_reg    <= '0;
            change_reg      <= '0;
            status_reg      <= 1'b0;
            strobe_reg      <= 1'b0;
            valid_reg       <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (take)
            begin
                state_reg       <= state_next;
                error_reg       <= error_next;
                module_reg      <= module_next;
                card_reg        <= card_next;
                restore_reg     <= restore_next;
                job_start_reg   <= job_start_next;
                phase_start_reg <= phase_start_next;
                act_base_reg    <= act_base_next;
                act_last_reg    <= act_last_next;
                change_reg      <= change_next;
                status_reg      <= status_next;
                strobe_reg      <= strobe_next;
            end
        end
    end

    assign res_valid           = valid_reg;
    assign res.job_state       = state_reg;
    assign res.error_code      = error_reg;
    assign res.start_status    = status_reg;
    assign res.send_strobe     = strobe_reg;
    assign res.send_is_restore = restore_reg;
    assign res.send_module     = module_reg;
    assign res.send_card       = card_reg;

`ifndef ASSERT_OFF
    a_strobe_enters_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        strobe_reg |-> (state_reg == ST_WAITING))
        else $error("send strobe without entering waiting");

    a_refuse_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        take && busy && ((item.func == FUNC_BACKUP) || (item.func == FUNC_RESTORE))
        |=> status_reg && $stable(state_reg))
        else $error("start while busy not refused");

    a_failed_has_error: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FAILED) |-> (error_reg != ERR_NONE))
        else $error("failed state without error code");

    a_state_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(state_reg) && $stable(status_reg) && $stable(strobe_reg))
        else $error("result changed without a transfer");
`endif

endmodule

/* sv/transfer_job_watchdog_fsm.sv */
// Transfer job watchdog, top level.
// Commands arrive on cmd (valid/ready): tick, start backup, start restore or
// clear. A tick carries the millisecond time, the transmit gate flag, the
// bus send acknowledge and the card activity counter. Each command gives
// exactly one result on res: job state, error code, start status, a send
// strobe for the tick on which the request frame went out, and the held
// operation and addresses for the frame builder outside this block.
// Limits are written through cfg_we/cfg_index/cfg_wdata; the user writes
// them only while idle, the block itself does not enforce this.
// Path: input register, then state machine and result register.
// Throughput: one command per cycle unless res stalls; the state update
// is one pass of 32-bit subtracts and compares between the two registers.
// When res is stalled the result register holds, the input register keeps
// one more command and cmd.ready stays low until res.ready returns; nothing
// is lost. Reset empties both registers, returns the job to idle with no
// error and loads the default limits.
// depends on tjw_pkg, tjw_if, tjw_cfg, tjw_in_stage and tjw_fsm
module transfer_job_watchdog_fsm
    import tjw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [CfgIdxW-1:0] cfg_index,
    input  logic [LimitW-1:0]  cfg_wdata,
    tjw_cmd_if.sink            cmd,
    tjw_res_if.source          res
);

    cfg_t cfg;
    cmd_t cmd_item;
    cmd_t item;
    logic item_valid;
    logic take;
    res_t result;

    assign cmd_item.func           = cmd.func;
    assign cmd_item.now_ms         = cmd.now_ms;
    assign cmd_item.module_address = cmd.module_address;
    assign cmd_item.card_address   = cmd.card_address;
    assign cmd_item.gate_open      = cmd.gate_open;
    assign cmd_item.send_ok        = cmd.send_ok;
    assign cmd_item.activity_count = cmd.activity_count;

    tjw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    tjw_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd.valid),
        .in_ready   (cmd.ready),
        .in_item    (cmd_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    tjw_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .res_valid  (res.valid),
        .res_ready  (res.ready),
        .res        (result)
    );

    assign res.job_state       = result.job_state;
    assign res.error_code      = result.error_code;
    assign res.start_status    = result.start_status;
    assign res.send_strobe     = result.send_strobe;
    assign res.send_is_restore = result.send_is_restore;
    assign res.send_module     = result.send_module;
    assign res.send_card       = result.send_card;

endmodule

/* sim/transfer_job_watchdog_fsm_test.sv */
// testbench for the transfer job watchdog: directed jobs, then random job sequences
// under several limit settings; a scoreboard class predicts and checks every status
// depends on tjw_pkg, tjw_if and the transfer_job_watchdog_fsm top level
module transfer_job_watchdog_fsm_test;
    import tjw_pkg::*;

    localparam int CycleLimit = 200000;

    typedef enum logic [2:0] {
        JOB_IDLE     = 3'd0,
        JOB_SENDING  = 3'd1,
        JOB_WAITING  = 3'd2,
        JOB_TRANSFER = 3'd3,
        JOB_DONE     = 3'd4,
        JOB_FAILED   = 3'd5
    } job_state_e;

    // mirror of the job state machine plus the queue of statuses still due
    class job_tracker;
        cfg_t             limits;
        job_state_e       state;
        logic [1:0]       err;
        logic [AddrW-1:0] held_mod;
        logic [AddrW-1:0] held_card;
        logic             held_restore;
        logic [TimeW-1:0] job_t0;
        logic [TimeW-1:0] phase_t0;
        logic [TimeW-1:0] act_base;
        logic [TimeW-1:0] act_last;
        logic [TimeW-1:0] last_change;
        res_t             status_due[$];
        int               errors;
        int               reports;

        function new();
            limits.send_timeout     = 16'd1000;
            limits.response_timeout = 16'd2000;
            limits.quiet_window     = 16'd500;
            limits.hard_cap         = 16'd30000;
            state        = JOB_IDLE;
            err          = ERR_NONE;
            held_mod     = '0;
            held_card    = '0;
            held_restore = 1'b0;
            job_t0       = '0;
            phase_t0     = '0;
            act_base     = '0;
            act_last     = '0;
            last_change  = '0;
            errors       = 0;
            reports      = 0;
        endfunction

        function void write_limit(logic [CfgIdxW-1:0] idx, logic [LimitW-1:0] v);
            case (idx)
                CFG_SEND_TIMEOUT:     limits.send_timeout = v;
                CFG_RESPONSE_TIMEOUT: limits.response_timeout = v;
                CFG_QUIET_WINDOW:     limits.quiet_window = v;
                CFG_HARD_CAP:         limits.hard_cap = v;
                default: ;
            endcase
        endfunction

        function bit busy();
            return state == JOB_SENDING || state == JOB_WAITING || state == JOB_TRANSFER;
        endfunction

        function bit finished();
            return state == JOB_DONE || state == JOB_FAILED;
        endfunction

        // commands that leave the job state and the held values as they were
        function bit ignored(cmd_t c);
            return (c.func == FUNC_TICK && !busy()) || (c.func == FUNC_CLEAR && !finished());
        endfunction

        // elapsed times wrap modulo 2^32, limits fire only when strictly exceeded
        function bit past(logic [TimeW-1:0] now, logic [TimeW-1:0] base,
                          logic [LimitW-1:0] lim);
            logic [TimeW-1:0] el;
            el = now - base;
            return el > {16'd0, lim};
        endfunction

        function logic run_tick(cmd_t c);
            case (state)
                JOB_SENDING:
                begin
                    if (past(c.now_ms, job_t0, limits.send_timeout))
                    begin
                        state = JOB_FAILED;
                        err   = ERR_SEND_TIMEOUT;
                        return 1'b0;
                    end
                    if (!c.gate_open || !c.send_ok)
                        return 1'b0;
                    act_base = c.activity_count;
                    act_last = c.activity_count;
                    phase_t0 = c.now_ms;
                    state    = JOB_WAITING;
                    return 1'b1;
                end
                JOB_WAITING:
                begin
                    if (c.activity_count != act_base)
                    begin
                        act_last    = c.activity_count;
                        last_change = c.now_ms;
                        state       = JOB_TRANSFER;
                    end
                    else if (past(c.now_ms, phase_t0, limits.response_timeout))
                    begin
                        state = JOB_FAILED;
                        err   = ERR_NO_RESPONSE;
                    end
                    return 1'b0;
                end
                JOB_TRANSFER:
                begin
                    if (c.activity_count != act_last)
                    begin
                        act_last    = c.activity_count;
                        last_change = c.now_ms;
                    end
                    // quiet window first, then the hard cap
                    if (past(c.now_ms, last_change, limits.quiet_window))
                        state = JOB_DONE;
                    else if (past(c.now_ms, job_t0, limits.hard_cap))
                        state = JOB_DONE;
                    return 1'b0;
                end
                default: return 1'b0;
            endcase
        endfunction

        function void accept_command(cmd_t c);
            res_t r;
            r = '0;
            if (c.func == FUNC_TICK)
                r.send_strobe = run_tick(c);
            else if (c.func == FUNC_CLEAR)
            begin
                if (finished())
                    state = JOB_IDLE;
            end
            else if (busy())
                r.start_status = 1'b1;
            else
            begin
                held_mod     = c.module_address;
                held_card    = c.card_address;
                held_restore = (c.func == FUNC_RESTORE);
                err          = ERR_NONE;
                job_t0       = c.now_ms;
                phase_t0     = c.now_ms;
                state        = JOB_SENDING;
            end
            r.job_state       = state;
            r.error_code      = err;
            r.send_is_restore = held_restore;
            r.send_module     = held_mod;
            r.send_card       = held_card;
            status_due.push_back(r);
        endfunction

        function void field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                errors++;
                reports++;
                if (reports <= 100)
                    $display("%0t mismatch %s: expected %0h, actual %0h",
                             $time, name, want, got);
            end
        endfunction

        function void check_status(res_t got);
            res_t want;
            if (status_due.size() == 0)
            begin
                errors++;
                reports++;
                if (reports <= 100)
                    $display("%0t unexpected status: expected none, actual %0h", $time, got);
                return;
            end
            want = status_due.pop_front();
            field("job_state", 32'(want.job_state), 32'(got.job_state));
            field("error_code", 32'(want.error_code), 32'(got.error_code));
            field("start_status", 32'(want.start_status), 32'(got.start_status));
            field("send_strobe", 32'(want.send_strobe), 32'(got.send_strobe));
            field("send_is_restore", 32'(want.send_is_restore),
                  32'(got.send_is_restore));
            field("send_module", 32'(want.send_module), 32'(got.send_module));
            field("send_card", 32'(want.send_card), 32'(got.send_card));
        endfunction

        function int pending();
            return status_due.size();
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [CfgIdxW-1:0] cfg_index;
    logic [LimitW-1:0]  cfg_wdata;

    tjw_cmd_if cmd_ch();
    tjw_res_if res_ch();

    transfer_job_watchdog_fsm i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .res       (res_ch)
    );

    job_tracker       sb;
    bit               calm;
    int               cycle_count;
    logic [TimeW-1:0] cur_now;
    logic [TimeW-1:0] cur_act;
    res_t             seen;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CycleLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // status side: back-pressure at random, sampled at the rising edge
    always @(negedge clk)
        res_ch.ready <= calm || ($urandom_range(0, 99) >= 15);

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid === 1'b1 && res_ch.ready)
        begin
            seen.job_state       = res_ch.job_state;
            seen.error_code      = res_ch.error_code;
            seen.start_status    = res_ch.start_status;
            seen.send_strobe     = res_ch.send_strobe;
            seen.send_is_restore = res_ch.send_is_restore;
            seen.send_module     = res_ch.send_module;
            seen.send_card       = res_ch.send_card;
            sb.check_status(seen);
        end
    end

    function bit take_break();
        return !calm && ($urandom_range(0, 99) < 15);
    endfunction

    // called and returns at a falling edge; valid stays up for a following transfer
    task automatic drive_cmd(cmd_t c);
        while (take_break())
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid          = 1'b1;
        cmd_ch.func           = c.func;
        cmd_ch.now_ms         = c.now_ms;
        cmd_ch.module_address = c.module_address;
        cmd_ch.card_address   = c.card_address;
        cmd_ch.gate_open      = c.gate_open;
        cmd_ch.send_ok        = c.send_ok;
        cmd_ch.activity_count = c.activity_count;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);
        sb.accept_command(c);
        @(negedge clk);
    endtask

    task automatic send(logic [1:0] func, logic [TimeW-1:0] now, logic [AddrW-1:0] md,
                        logic [AddrW-1:0] cd, logic gate, logic ok, logic [TimeW-1:0] act);
        cmd_t c;
        c.func           = func;
        c.now_ms         = now;
        c.module_address = md;
        c.card_address   = cd;
        c.gate_open      = gate;
        c.send_ok        = ok;
        c.activity_count = act;
        drive_cmd(c);
    endtask

    // wait for every status, then let the pipeline empty
    task automatic settle();
        cmd_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_limits(logic [LimitW-1:0] st, logic [LimitW-1:0] rt,
                               logic [LimitW-1:0] qw, logic [LimitW-1:0] hc);
        logic [LimitW-1:0] vals[4];
        vals = '{st, rt, qw, hc};
        settle();
        cfg_we = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            cfg_index = CfgIdxW'(i);
            cfg_wdata = vals[i];
            sb.write_limit(CfgIdxW'(i), vals[i]);
            @(negedge clk);
        end
        cfg_we = 1'b0;
    endtask

    // mostly creep towards the limit, sometimes land right on it or jump anywhere
    function logic [TimeW-1:0] next_time(logic [TimeW-1:0] base, logic [LimitW-1:0] lim);
        logic [TimeW-1:0] el;
        int               roll;
        el   = cur_now - base;
        roll = $urandom_range(0, 99);
        if (roll < 15 && el <= {16'd0, lim})
            return base + {16'd0, lim} + $urandom_range(0, 1);
        if (roll < 18)
            return $urandom;
        return cur_now + $urandom_range(0, int'(lim) / 6 + 2);
    endfunction

    task automatic random_item(output cmd_t c);
        int                roll;
        logic [TimeW-1:0]  base;
        logic [LimitW-1:0] lim;
        c.module_address = AddrW'($urandom);
        c.card_address   = AddrW'($urandom);
        c.gate_open      = $urandom_range(0, 3) != 0;
        c.send_ok        = $urandom_range(0, 3) != 0;
        roll = $urandom_range(0, 99);
        if (!sb.busy())
        begin
            if (roll < 65)
            begin
                c.func = $urandom_range(0, 1) ? FUNC_RESTORE : FUNC_BACKUP;
                if ($urandom_range(0, 9) == 0)
                    cur_now = 32'hFFFF_FFFF - $urandom_range(0, 40000);
                else
                    cur_now = cur_now + $urandom_range(0, 300);
            end
            else if (roll < 85)
                c.func = FUNC_CLEAR;
            else
            begin
                c.func  = FUNC_TICK;
                cur_now = cur_now + $urandom_range(0, 100);
            end
        end
        else if (roll < 6)
        begin
            c.func  = $urandom_range(0, 1) ? FUNC_RESTORE : FUNC_BACKUP;
            cur_now = cur_now + $urandom_range(0, 50);
        end
        else if (roll < 10)
            c.func = FUNC_CLEAR;
        else
        begin
            c.func = FUNC_TICK;
            base   = sb.job_t0;
            lim    = sb.limits.send_timeout;
            if (sb.state == JOB_WAITING)
            begin
                base = sb.phase_t0;
                lim  = sb.limits.response_timeout;
                if ($urandom_range(0, 99) < 30)
                    cur_act = cur_act + $urandom_range(1, 1000);
            end
            else if (sb.state == JOB_TRANSFER)
            begin
                if ($urandom_range(0, 1))
                begin
                    base = sb.last_change;
                    lim  = sb.limits.quiet_window;
                end
                else
                    lim = sb.limits.hard_cap;
                if ($urandom_range(0, 99) < 35)
                    cur_act = $urandom_range(0, 3) == 0 ? $urandom
                                                        : cur_act + $urandom_range(1, 1000);
            end
            cur_now = next_time(base, lim);
        end
        c.now_ms         = cur_now;
        c.activity_count = cur_act;
    endtask

    task automatic run_random(int quota);
        cmd_t c;
        int   n;
        n = 0;
        while (n < quota)
        begin
            random_item(c);
            if (!sb.ignored(c))
                n++;
            drive_cmd(c);
        end
    endtask

    initial
    begin
        sb                    = new();
        calm                  = 1'b0;
        cycle_count           = 0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_SEND_TIMEOUT;
        cfg_wdata             = '0;
        cmd_ch.valid          = 1'b0;
        cmd_ch.func           = FUNC_TICK;
        cmd_ch.now_ms         = '0;
        cmd_ch.module_address = '0;
        cmd_ch.card_address   = '0;
        cmd_ch.gate_open      = 1'b0;
        cmd_ch.send_ok        = 1'b0;
        cmd_ch.activity_count = '0;
        res_ch.ready          = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed jobs on the default limits
        send(FUNC_TICK, 32'h0, 7'd0, 7'd0, 1'b0, 1'b0, 32'h0);
        send(FUNC_CLEAR, 32'h0, 7'd127, 7'd127, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send(FUNC_BACKUP, 32'hFFFF_FF00, 7'd127, 7'd0, 1'b0, 1'b0, 32'h0);
        send(FUNC_RESTORE, 32'hFFFF_FF10, 7'd1, 7'd2, 1'b1, 1'b1, 32'h0);
        send(FUNC_CLEAR, 32'hFFFF_FF10, 7'd0, 7'd0, 1'b0, 1'b0, 32'h0);
        // send timeout boundary across the wrap, gate and ack each missing
        send(FUNC_TICK, 32'h0000_02E8, 7'd0, 7'd0, 1'b0, 1'b1, 32'h0);
        send(FUNC_TICK, 32'h0000_02E8, 7'd0, 7'd0, 1'b1, 1'b0, 32'h0);
        send(FUNC_TICK, 32'h0000_02E8, 7'd0, 7'd0, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send(FUNC_TICK, 32'h0000_0AB8, 7'd0, 7'd0, 1'b1, 1'b1, 32'hFFFF_FFFF);
        send(FUNC_TICK, 32'h0000_0AB8, 7'd0, 7'd0, 1'b0, 1'b0, 32'h0);
        send(FUNC_TICK, 32'h0000_0CAC, 7'd0, 7'd0, 1'b0, 1'b0, 32'h0);
        send(FUNC_TICK, 32'h0000_0CAD, 7'd0, 7'd0, 1'b0, 1'b0, 32'h0);
        // restart from done, then time out while sending even with the bus ready
        send(FUNC_RESTORE, 32'd1000, 7'd0, 7'd127, 1'b0, 1'b0, 32'h0);
        send(FUNC_TICK, 32'd2001, 7'd0, 7'd0, 1'b1, 1'b1, 32'h0);
        send(FUNC_CLEAR, 32'd2001, 7'd0, 7'd0, 1'b0, 1'b0, 32'h0);
        // no response after the frame went out
        send(FUNC_BACKUP, 32'd0, 7'd55, 7'd42, 1'b0, 1'b0, 32'h0);
        send(FUNC_TICK, 32'd5, 7'd0, 7'd0, 1'b1, 1'b1, 32'h1234_5678);
        send(FUNC_TICK, 32'd2006, 7'd0, 7'd0, 1'b1, 1'b1, 32'h1234_5678);
        // hard cap reached while activity keeps moving
        send(FUNC_RESTORE, 32'd100, 7'd99, 7'd3, 1'b0, 1'b0, 32'h0);
        send(FUNC_TICK, 32'd100, 7'd0, 7'd0, 1'b1, 1'b1, 32'h1234_5678);
        send(FUNC_TICK, 32'd200, 7'd0, 7'd0, 1'b1, 1'b1, 32'hAAAA_AAAA);
        send(FUNC_TICK, 32'd30101, 7'd0, 7'd0, 1'b1, 1'b1, 32'h5555_5555);
        send(FUNC_CLEAR, 32'd30101, 7'd0, 7'd0, 1'b0, 1'b0, 32'h0);
        cur_now = 32'd30101;
        cur_act = 32'h5555_5555;

        run_random(80);
        load_limits(16'd0, 16'd0, 16'd0, 16'd0);
        run_random(80);
        // long stretch with no idling on either side
        calm = 1'b1;
        load_limits(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        run_random(85);
        calm = 1'b0;
        load_limits(LimitW'($urandom), LimitW'($urandom),
                    LimitW'($urandom), LimitW'($urandom));
        run_random(85);
        load_limits(LimitW'($urandom_range(1, 50)), LimitW'($urandom_range(1, 50)),
                    LimitW'($urandom_range(1, 50)), LimitW'($urandom_range(1, 200)));
        run_random(85);
        load_limits(LimitW'($urandom_range(0, 3000)), LimitW'($urandom_range(0, 3000)),
                    LimitW'($urandom_range(0, 1000)), LimitW'($urandom_range(0, 8000)));
        run_random(85);

        cmd_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
